// ===== rtl/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types and constants for the integer to ASCII text formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  // parameter defaults
  localparam int unsigned MaxCharsDef  = 64;
  localparam int unsigned ValueBitsDef = 64;

  // style codes
  localparam logic [2:0] CMD_UDEC    = 3'd0;
  localparam logic [2:0] CMD_SDEC    = 3'd1;
  localparam logic [2:0] CMD_BIN     = 3'd2;
  localparam logic [2:0] CMD_HEX_LO  = 3'd3;
  localparam logic [2:0] CMD_HEX_UP  = 3'd4;

  // character codes
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_MINUS   = 8'h2d;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [3:0] DEC_BASE     = 4'd10;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic conv_step;
    logic strip_step;
    logic emit_step;
    logic empty_sel;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_empty;
    logic in_decimal;
    logic conv_last;
    logic strip_more;
    logic emit_last;
  } ctrl_sts_t;

endpackage

// ===== rtl/itoa_ctrl.sv =====
// ----------------------------------------------------------------------------
// itoa_ctrl
// Sequencing state machine: load, binary to BCD (decimal only), leading zero strip, emit, or an empty result.
// ----------------------------------------------------------------------------
module itoa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  itoa_pkg::ctrl_sts_t sts_i,
  output itoa_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CONV  = 5'b00010,
    ST_STRIP = 5'b00100,
    ST_EMIT  = 5'b01000,
    ST_EMPTY = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.in_empty) begin
            state_d = ST_EMPTY;
          end else if (sts_i.in_decimal) begin
            state_d = ST_CONV;
          end else begin
            state_d = ST_STRIP;
          end
        end
      end
      ST_CONV: begin
        cmd_o.conv_step = 1'b1;
        if (sts_i.conv_last) begin
          state_d = ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (sts_i.strip_more) begin
          cmd_o.strip_step = 1'b1;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_o     = 1'b1;
        cmd_o.emit_step = out_ready_i;
        if (out_ready_i && sts_i.emit_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        out_valid_o     = 1'b1;
        cmd_o.empty_sel = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/itoa_datapath.sv =====
// ----------------------------------------------------------------------------
// itoa_datapath
// Digit shift register, serial double dabble, grouping and character select.
// ----------------------------------------------------------------------------
module itoa_datapath #(
  parameter int unsigned MAX_CHARS  = itoa_pkg::MaxCharsDef,
  parameter int unsigned VALUE_BITS = itoa_pkg::ValueBitsDef
) (
  input  logic                clk_i,
  input  logic [63:0]         value_i,
  input  logic [2:0]          command_i,
  input  logic [7:0]          delimiter_i,
  input  logic [6:0]          max_chars_i,
  input  itoa_pkg::ctrl_cmd_t cmd_i,
  output itoa_pkg::ctrl_sts_t sts_o,
  output logic [7:0]          out_char_o,
  output logic                last_o,
  output logic                empty_res_o
);

  // decimal digits for the BCD register, at least enough for VALUE_BITS
  localparam int unsigned NumDec = VALUE_BITS / 3 + 1;
  localparam int unsigned NumHex = (VALUE_BITS + 3) / 4;
  localparam int unsigned SrW    = 4 * NumDec;
  localparam int unsigned CntW   = $clog2(SrW + 1);
  localparam int unsigned BudW   = $clog2(MAX_CHARS + 1);
  localparam int unsigned BinSh  = SrW - VALUE_BITS;
  localparam int unsigned HexSh  = SrW - 4 * NumHex;
  localparam logic [1:0]  Grp0   = (NumDec % 3 == 0) ? 2'd3 : 2'((NumDec % 3));

  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [SrW-1:0]        sr_q, sr_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [BudW-1:0]       bud_q, bud_d;
  logic [1:0]            grp_q, grp_d;
  logic [1:0]            pos_q, pos_d;
  logic                  dlm_pend_q, dlm_pend_d;
  logic                  sign_q, sign_d;
  logic                  dec_q, dec_d;
  logic                  wide_q, wide_d;
  logic                  upper_q, upper_d;
  logic [7:0]            delim_q, delim_d;

  logic [VALUE_BITS-1:0] v_in, mag;
  logic                  neg;
  logic                  in_dec, in_hex;
  logic [BudW-1:0]       bud_in;
  logic [SrW-1:0]        bcd_adj, sr_shift;
  logic [3:0]            top_dig;
  logic                  is_delim;
  logic [7:0]            letter, digit_char;
  logic                  emit_last;
  logic [1:0]            grp_dec;

  assign v_in   = value_i[VALUE_BITS-1:0];
  assign neg    = (command_i == itoa_pkg::CMD_SDEC) && v_in[VALUE_BITS-1];
  assign mag    = neg ? (~v_in + VALUE_BITS'(1)) : v_in;
  assign in_dec = (command_i == itoa_pkg::CMD_UDEC) || (command_i == itoa_pkg::CMD_SDEC);
  assign in_hex = (command_i == itoa_pkg::CMD_HEX_LO) || (command_i == itoa_pkg::CMD_HEX_UP);
  assign bud_in = (max_chars_i > 7'(MAX_CHARS)) ? BudW'(MAX_CHARS) : BudW'(max_chars_i);

  // add three to every BCD digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NumDec; i++) begin
      bcd_adj[i*4 +: 4] = (sr_q[i*4 +: 4] >= 4'd5) ? (sr_q[i*4 +: 4] + 4'd3)
                                                    : sr_q[i*4 +: 4];
    end
  end

  assign top_dig    = wide_q ? sr_q[SrW-1 -: 4] : {3'b000, sr_q[SrW-1]};
  assign sr_shift   = wide_q ? (sr_q << 4) : (sr_q << 1);
  assign is_delim   = dec_q ? dlm_pend_q : ((delim_q != 8'd0) && (pos_q == 2'd3));
  assign letter     = upper_q ? itoa_pkg::CHAR_UPPER_A : itoa_pkg::CHAR_LOWER_A;
  assign digit_char = (top_dig < itoa_pkg::DEC_BASE)
                    ? (itoa_pkg::CHAR_ZERO + {4'd0, top_dig})
                    : (letter + {4'd0, top_dig} - {4'd0, itoa_pkg::DEC_BASE});
  assign emit_last  = (bud_q == BudW'(1)) ||
                      (!sign_q && !is_delim && (cnt_q == CntW'(1)));
  assign grp_dec    = (grp_q == 2'd1) ? 2'd3 : (grp_q - 2'd1);

  always_comb begin
    bin_d      = bin_q;
    sr_d       = sr_q;
    cnt_d      = cnt_q;
    bud_d      = bud_q;
    grp_d      = grp_q;
    pos_d      = pos_q;
    dlm_pend_d = dlm_pend_q;
    sign_d     = sign_q;
    dec_d      = dec_q;
    wide_d     = wide_q;
    upper_d    = upper_q;
    delim_d    = delim_q;
    if (cmd_i.load) begin
      bin_d      = mag;
      cnt_d      = in_dec ? CntW'(VALUE_BITS) : (in_hex ? CntW'(NumHex) : CntW'(VALUE_BITS));
      if (in_dec) begin
        sr_d = '0;
      end else if (in_hex) begin
        sr_d = SrW'(v_in) << HexSh;
      end else begin
        sr_d = SrW'(v_in) << BinSh;
      end
      bud_d      = bud_in;
      grp_d      = Grp0;
      pos_d      = 2'd0;
      dlm_pend_d = 1'b0;
      sign_d     = neg;
      dec_d      = in_dec;
      wide_d     = in_dec || in_hex;
      upper_d    = (command_i == itoa_pkg::CMD_HEX_UP);
      delim_d    = delimiter_i;
    end else if (cmd_i.conv_step) begin
      sr_d  = {bcd_adj[SrW-2:0], bin_q[VALUE_BITS-1]};
      bin_d = bin_q << 1;
      cnt_d = (cnt_q == CntW'(1)) ? CntW'(NumDec) : (cnt_q - CntW'(1));
    end else if (cmd_i.strip_step) begin
      sr_d  = sr_shift;
      cnt_d = cnt_q - CntW'(1);
      grp_d = grp_dec;
    end else if (cmd_i.emit_step) begin
      bud_d = bud_q - BudW'(1);
      if (sign_q) begin
        sign_d = 1'b0;
      end else if (is_delim) begin
        dlm_pend_d = 1'b0;
        pos_d      = pos_q + 2'd1;
      end else begin
        sr_d  = sr_shift;
        cnt_d = cnt_q - CntW'(1);
        pos_d = pos_q + 2'd1;
        grp_d = grp_dec;
        // a group just closed with digits still to come
        if (grp_q == 2'd1) begin
          dlm_pend_d = (delim_q != 8'd0) && (cnt_q != CntW'(1));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q      <= bin_d;
    sr_q       <= sr_d;
    cnt_q      <= cnt_d;
    bud_q      <= bud_d;
    grp_q      <= grp_d;
    pos_q      <= pos_d;
    dlm_pend_q <= dlm_pend_d;
    sign_q     <= sign_d;
    dec_q      <= dec_d;
    wide_q     <= wide_d;
    upper_q    <= upper_d;
    delim_q    <= delim_d;
  end

  assign sts_o.in_empty   = (max_chars_i == 7'd0) || (command_i > itoa_pkg::CMD_HEX_UP);
  assign sts_o.in_decimal = in_dec;
  assign sts_o.conv_last  = (cnt_q == CntW'(1));
  assign sts_o.strip_more = (cnt_q > CntW'(1)) && (top_dig == 4'd0);
  assign sts_o.emit_last  = emit_last;

  assign out_char_o  = cmd_i.empty_sel ? itoa_pkg::CHAR_NUL
                     : sign_q ? itoa_pkg::CHAR_MINUS
                     : is_delim ? delim_q : digit_char;
  assign last_o      = cmd_i.empty_sel || emit_last;
  assign empty_res_o = cmd_i.empty_sel;

endmodule

// ===== rtl/integer_to_ascii_formatter.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Prints a value as decimal, signed decimal, binary or hex text, one
// character per output transfer, with optional digit grouping.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i/in_ready_o   | value, command, delimiter, max_chars
//  out     | output    | out_valid_o/out_ready_i | out_char, last, empty_res
//
//  one item at a time; a new input transfer is taken from the cycle after the
//  last character of the previous item has been transferred
//  decimal styles: serial double dabble over all VALUE_BITS bits, then strip of up
//  to VALUE_BITS/3 leading zero digits, then emit, one character per transfer
//  binary/hex: leading zero strip (one digit per step), then emit
//  out stalls only hold the current character; reset returns to idle
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter #(
  parameter int unsigned MAX_CHARS  = itoa_pkg::MaxCharsDef,
  parameter int unsigned VALUE_BITS = itoa_pkg::ValueBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] value_i,
  input  logic [2:0]  command_i,
  input  logic [7:0]  delimiter_i,
  input  logic [6:0]  max_chars_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_char_o,
  output logic        last_o,
  output logic        empty_res_o
);

  itoa_pkg::ctrl_cmd_t cmd;
  itoa_pkg::ctrl_sts_t sts;

  itoa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  itoa_datapath #(
    .MAX_CHARS  (MAX_CHARS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .value_i     (value_i),
    .command_i   (command_i),
    .delimiter_i (delimiter_i),
    .max_chars_i (max_chars_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_char_o  (out_char_o),
    .last_o      (last_o),
    .empty_res_o (empty_res_o)
  );

  // an empty result always closes its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_res_o |-> last_o)
    else $error("empty result without last");

  // busy right after an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken twice in a row");

  // never ready for input while a character is offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready during output");

  // the final character of an item returns the block to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_o |=> in_ready_o)
    else $error("not idle after last transfer");

endmodule
